/* rtl/core/text_console_cursor_engine_macros.svh */
// Assertion macros shared by the console engine modules.
// Each macro expects clk and rst_n to be visible where it is used.
`ifndef TEXT_CONSOLE_CURSOR_ENGINE_MACROS_SVH
`define TEXT_CONSOLE_CURSOR_ENGINE_MACROS_SVH

// A property that must hold at every clock edge outside reset.
`define TCCE_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// A condition that must be followed in the next cycle by a consequence.
`define TCCE_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

/* rtl/core/tcce_pkg.sv */
// Types and constants for the text console cursor engine.
// Used by the controller, the datapath and the top level; depends on nothing.
package tcce_pkg;

    // Configuration port
    localparam int APB_ADDR_W = 3;
    localparam int APB_DATA_W = 32;
    localparam logic [0:0] REG_BACKGROUND = 1'b0;

    // Character handling
    localparam int         TAB_STOP       = 4;
    localparam logic [7:0] BLANK          = 8'h20;
    localparam logic [7:0] CHAR_BACKSPACE = 8'h08;
    localparam logic [7:0] CHAR_TAB       = 8'h09;
    localparam logic [7:0] CHAR_NEWLINE   = 8'h0A;
    localparam logic [7:0] CHAR_RETURN    = 8'h0D;
    localparam logic [15:0] RESET_COLOUR  = 16'h07E0;

    // Input modes
    localparam logic [1:0] MODE_WRITE  = 2'd0;
    localparam logic [1:0] MODE_CURSOR = 2'd1;
    localparam logic [1:0] MODE_CLEAR  = 2'd2;

    // Result commands
    localparam logic [1:0] CMD_DRAW   = 2'd0;
    localparam logic [1:0] CMD_SCROLL = 2'd1;
    localparam logic [1:0] CMD_FILL   = 2'd2;

    typedef struct packed {
        logic [1:0]  mode;
        logic [7:0]  char_code;
        logic [15:0] text_colour;
        logic        cursor_visible;
    } item_t;

    typedef struct packed {
        logic [1:0]  command;
        logic [5:0]  cell_column;
        logic [3:0]  cell_row;
        logic [7:0]  glyph_code;
        logic [15:0] glyph_colour;
        logic        inverted;
        logic        last_command;
    } result_t;

    // Where a result's fields come from
    typedef enum logic [2:0] {
        SRC_PLAIN  = 3'd0,
        SRC_VIS    = 3'd1,
        SRC_PUT    = 3'd2,
        SRC_BS     = 3'd3,
        SRC_SCROLL = 3'd4,
        SRC_CLEAR  = 3'd5
    } src_t;

    typedef enum logic [2:0] {
        CUR_HOLD    = 3'd0,
        CUR_ADVANCE = 3'd1,
        CUR_NEWLINE = 3'd2,
        CUR_RETURN  = 3'd3,
        CUR_BACK    = 3'd4
    } cur_op_t;

    typedef struct packed {
        logic    load;
        logic    rd_cell;
        logic    wr_cell;
        logic    emit;
        src_t    src;
        cur_op_t cur_op;
        logic    scroll;
        logic    clear;
        logic    sweep;
        logic    tab_dec;
        logic    finish;
    } dp_cmd_t;

    typedef struct packed {
        logic [1:0] mode;
        logic       is_newline;
        logic       is_return;
        logic       is_backspace;
        logic       shown;
        logic       vis_match;
        logic       last_col;
        logic       last_row;
        logic       rem_one;
        logic       rem_zero;
        logic       sweep_last;
        logic       out_free;
        logic       held_valid;
    } dp_status_t;

endpackage

/* rtl/core/tcce_dp.sv */
// Datapath of the console engine: cursor, ring offset, cell memory, result staging.
// Depends on tcce_pkg and the assertion macros header.
`include "text_console_cursor_engine_macros.svh"

module tcce_dp #(
    parameter int COLUMNS = 40,
    parameter int ROWS    = 16
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  tcce_pkg::dp_cmd_t    cmd,
    output tcce_pkg::dp_status_t status,
    input  tcce_pkg::item_t      item,
    input  logic [15:0]          background_colour,
    output logic                 result_valid,
    output tcce_pkg::result_t    result,
    input  logic                 result_stall
);
    import tcce_pkg::*;

    localparam int COL_W  = $clog2(COLUMNS);
    localparam int ROW_W  = $clog2(ROWS);
    localparam int SUM_W  = ROW_W + 1;
    localparam int CELLS  = COLUMNS * ROWS;
    localparam int ADDR_W = $clog2(CELLS);
    localparam logic [COL_W-1:0]  LAST_COL      = COL_W'(COLUMNS - 1);
    localparam logic [ROW_W-1:0]  LAST_ROW      = ROW_W'(ROWS - 1);
    localparam logic [ADDR_W-1:0] LAST_CELL     = ADDR_W'(CELLS - 1);
    localparam logic [ADDR_W-1:0] ROW_LAST_CELL = ADDR_W'(COLUMNS - 1);

    item_t              item_reg;
    logic [COL_W-1:0]   cur_col_reg, cur_col_next;
    logic [ROW_W-1:0]   cur_row_reg, cur_row_next;
    logic [ROW_W-1:0]   top_reg, top_next;
    logic               shown_reg, shown_next;
    logic [2:0]         rem_reg, rem_next;
    logic [ADDR_W-1:0]  sweep_addr_reg, sweep_addr_next;
    logic [ADDR_W-1:0]  sweep_count_reg, sweep_count_next;
    logic [15:0]        sweep_colour_reg, sweep_colour_next;
    logic               held_valid_reg, held_valid_next;
    result_t            held_reg;
    logic               result_valid_reg, result_valid_next;
    result_t            result_reg;
    logic [23:0]        rd_data_reg;

    logic [SUM_W-1:0]   phys_sum;
    logic [ROW_W-1:0]   phys_row;
    logic [ADDR_W-1:0]  cell_addr;
    logic [7:0]         rd_char;
    logic [15:0]        rd_colour;
    logic [7:0]         put_glyph;
    result_t            new_res;
    result_t            push_res;
    logic               push;
    logic               mem_we;
    logic [ADDR_W-1:0]  mem_waddr;
    logic [23:0]        mem_wdata;
    logic [23:0]        cell_mem [CELLS];

    // Logical rows sit in a ring; the top row offset picks the physical row.
    always_comb
    begin
        phys_sum = {1'b0, cur_row_reg} + {1'b0, top_reg};
        if (phys_sum >= SUM_W'(ROWS))
        begin
            phys_row = ROW_W'(phys_sum - SUM_W'(ROWS));
        end
        else
        begin
            phys_row = ROW_W'(phys_sum);
        end
        cell_addr = ADDR_W'(phys_row) * ADDR_W'(COLUMNS) + ADDR_W'(cur_col_reg);
    end

    assign rd_char   = rd_data_reg[23:16];
    assign rd_colour = rd_data_reg[15:0];
    assign put_glyph = (item_reg.char_code == CHAR_TAB) ? BLANK : item_reg.char_code;

    always_comb
    begin
        new_res              = '0;
        new_res.command      = CMD_DRAW;
        new_res.cell_column  = 6'(cur_col_reg);
        new_res.cell_row     = 4'(cur_row_reg);
        case (cmd.src)
            SRC_PLAIN:
            begin
                new_res.glyph_code   = rd_char;
                new_res.glyph_colour = rd_colour;
            end
            SRC_VIS:
            begin
                new_res.glyph_code   = rd_char;
                new_res.glyph_colour = item_reg.text_colour;
                new_res.inverted     = item_reg.cursor_visible;
            end
            SRC_PUT:
            begin
                new_res.glyph_code   = put_glyph;
                new_res.glyph_colour = item_reg.text_colour;
            end
            SRC_BS:
            begin
                new_res.glyph_code   = BLANK;
                new_res.glyph_colour = rd_colour;
            end
            SRC_SCROLL:
            begin
                new_res.command      = CMD_SCROLL;
                new_res.cell_column  = 6'd0;
                new_res.cell_row     = 4'(ROWS - 1);
                new_res.glyph_code   = BLANK;
                new_res.glyph_colour = item_reg.text_colour;
            end
            SRC_CLEAR:
            begin
                new_res.command      = CMD_FILL;
                new_res.cell_column  = 6'd0;
                new_res.cell_row     = 4'd0;
                new_res.glyph_code   = BLANK;
                new_res.glyph_colour = background_colour;
            end
            default:
            begin
                new_res.glyph_code   = BLANK;
            end
        endcase
    end

    // Draw-beat cell writes store the beat's glyph and colour; sweeps write blanks.
    assign mem_we    = cmd.sweep || cmd.wr_cell;
    assign mem_waddr = cmd.sweep ? sweep_addr_reg : cell_addr;
    assign mem_wdata = cmd.sweep ? {BLANK, sweep_colour_reg}
                                 : {new_res.glyph_code, new_res.glyph_colour};

    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            cell_mem[mem_waddr] <= mem_wdata;
        end
        if (cmd.rd_cell)
        begin
            rd_data_reg <= cell_mem[cell_addr];
        end
    end

    // The newest result waits in the holding register until it is known
    // whether another one follows, which settles its last flag.
    assign push = (cmd.emit || cmd.finish) && held_valid_reg;

    always_comb
    begin
        push_res              = held_reg;
        push_res.last_command = cmd.finish;
    end

    always_comb
    begin
        cur_col_next      = cur_col_reg;
        cur_row_next      = cur_row_reg;
        top_next          = top_reg;
        shown_next        = shown_reg;
        rem_next          = rem_reg;
        sweep_addr_next   = sweep_addr_reg;
        sweep_count_next  = sweep_count_reg;
        sweep_colour_next = sweep_colour_reg;
        held_valid_next   = held_valid_reg;

        case (cmd.cur_op)
            CUR_ADVANCE:
            begin
                cur_col_next = cur_col_reg + 1'b1;
            end
            CUR_NEWLINE:
            begin
                cur_col_next = '0;
                if (cur_row_reg != LAST_ROW)
                begin
                    cur_row_next = cur_row_reg + 1'b1;
                end
            end
            CUR_RETURN:
            begin
                cur_col_next = '0;
            end
            CUR_BACK:
            begin
                if (cur_col_reg != '0)
                begin
                    cur_col_next = cur_col_reg - 1'b1;
                end
                else if (cur_row_reg != '0)
                begin
                    cur_row_next = cur_row_reg - 1'b1;
                    cur_col_next = LAST_COL;
                end
            end
            default:
            begin
                cur_col_next = cur_col_reg;
            end
        endcase

        if (cmd.clear)
        begin
            cur_col_next      = '0;
            cur_row_next      = '0;
            top_next          = '0;
            sweep_addr_next   = '0;
            sweep_count_next  = LAST_CELL;
            sweep_colour_next = item_reg.text_colour;
        end

        // After the offset moves on, the old top row becomes the new bottom row.
        if (cmd.scroll)
        begin
            top_next          = (top_reg == LAST_ROW) ? '0 : top_reg + 1'b1;
            sweep_addr_next   = ADDR_W'(top_reg) * ADDR_W'(COLUMNS);
            sweep_count_next  = ROW_LAST_CELL;
            sweep_colour_next = item_reg.text_colour;
        end

        if (cmd.sweep)
        begin
            sweep_addr_next  = sweep_addr_reg + 1'b1;
            sweep_count_next = sweep_count_reg - 1'b1;
        end

        if (cmd.emit && (cmd.src == SRC_PLAIN))
        begin
            shown_next = 1'b0;
        end
        else if (cmd.emit && (cmd.src == SRC_VIS))
        begin
            shown_next = item_reg.cursor_visible;
        end

        // Spaces still to print: up to the next tab stop, one for a printable
        // character, none for anything else.
        if (cmd.load)
        begin
            if (item.mode != MODE_WRITE)
            begin
                rem_next = 3'd0;
            end
            else if (item.char_code == CHAR_TAB)
            begin
                rem_next = 3'(TAB_STOP) - {1'b0, cur_col_reg[1:0]};
            end
            else if (item.char_code >= BLANK)
            begin
                rem_next = 3'd1;
            end
            else
            begin
                rem_next = 3'd0;
            end
        end
        else if (cmd.tab_dec)
        begin
            rem_next = rem_reg - 1'b1;
        end

        if (cmd.emit)
        begin
            held_valid_next = 1'b1;
        end
        else if (cmd.finish)
        begin
            held_valid_next = 1'b0;
        end

        if (push)
        begin
            result_valid_next = 1'b1;
        end
        else
        begin
            result_valid_next = result_valid_reg && result_stall;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cur_col_reg      <= '0;
            cur_row_reg      <= '0;
            top_reg          <= '0;
            shown_reg        <= 1'b0;
            rem_reg          <= '0;
            sweep_addr_reg   <= '0;
            sweep_count_reg  <= LAST_CELL;
            sweep_colour_reg <= RESET_COLOUR;
            held_valid_reg   <= 1'b0;
            result_valid_reg <= 1'b0;
        end
        else
        begin
            cur_col_reg      <= cur_col_next;
            cur_row_reg      <= cur_row_next;
            top_reg          <= top_next;
            shown_reg        <= shown_next;
            rem_reg          <= rem_next;
            sweep_addr_reg   <= sweep_addr_next;
            sweep_count_reg  <= sweep_count_next;
            sweep_colour_reg <= sweep_colour_next;
            held_valid_reg   <= held_valid_next;
            result_valid_reg <= result_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            item_reg <= item;
        end
        if (cmd.emit)
        begin
            held_reg <= new_res;
        end
        if (push)
        begin
            result_reg <= push_res;
        end
    end

    assign result_valid = result_valid_reg;
    assign result       = result_reg;

    always_comb
    begin
        status              = '0;
        status.mode         = item_reg.mode;
        status.is_newline   = item_reg.char_code == CHAR_NEWLINE;
        status.is_return    = item_reg.char_code == CHAR_RETURN;
        status.is_backspace = item_reg.char_code == CHAR_BACKSPACE;
        status.shown        = shown_reg;
        status.vis_match    = item_reg.cursor_visible == shown_reg;
        status.last_col     = cur_col_reg == LAST_COL;
        status.last_row     = cur_row_reg == LAST_ROW;
        status.rem_one      = rem_reg == 3'd1;
        status.rem_zero     = rem_reg == 3'd0;
        status.sweep_last   = sweep_count_reg == '0;
        status.out_free     = !result_valid_reg || !result_stall;
        status.held_valid   = held_valid_reg;
    end

    `TCCE_ASSERT(a_no_overwrite, !(push && result_valid_reg && result_stall), "result beat overwritten while stalled")
    `TCCE_ASSERT(a_cursor_range, (cur_col_reg <= LAST_COL) && (cur_row_reg <= LAST_ROW), "cursor left the grid")
    `TCCE_ASSERT_NEXT(a_scroll_bottom, cmd.scroll, cur_row_reg == LAST_ROW, "cursor not on bottom row after scroll")

endmodule

/* rtl/core/tcce_ctrl.sv */
// Sequencer of the console engine: steps one input item through its results.
// Depends on tcce_pkg and the assertion macros header.
`include "text_console_cursor_engine_macros.svh"

module tcce_ctrl (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 item_valid,
    output logic                 item_stall,
    input  tcce_pkg::dp_status_t status,
    output tcce_pkg::dp_cmd_t    cmd
);
    import tcce_pkg::*;

    typedef enum logic [12:0] {
        S_INIT     = 13'b0000000000001,
        S_IDLE     = 13'b0000000000010,
        S_DISPATCH = 13'b0000000000100,
        S_CUR_DRAW = 13'b0000000001000,
        S_CHAR     = 13'b0000000010000,
        S_PUT      = 13'b0000000100000,
        S_SCROLL   = 13'b0000001000000,
        S_SWEEP    = 13'b0000010000000,
        S_BS_READ  = 13'b0000100000000,
        S_BS_DRAW  = 13'b0001000000000,
        S_VIS_DRAW = 13'b0010000000000,
        S_CLEAR    = 13'b0100000000000,
        S_FINISH   = 13'b1000000000000
    } state_t;

    state_t state_reg, state_next;

    assign item_stall = state_reg != S_IDLE;

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        cmd.src    = SRC_PLAIN;
        cmd.cur_op = CUR_HOLD;
        case (state_reg)
            // Memory clearing pass after reset.
            S_INIT:
            begin
                cmd.sweep = 1'b1;
                if (status.sweep_last)
                begin
                    state_next = S_IDLE;
                end
            end
            S_IDLE:
            begin
                if (item_valid)
                begin
                    cmd.load   = 1'b1;
                    state_next = S_DISPATCH;
                end
            end
            S_DISPATCH:
            begin
                case (status.mode)
                    MODE_WRITE:
                    begin
                        if (status.shown)
                        begin
                            cmd.rd_cell = 1'b1;
                            state_next  = S_CUR_DRAW;
                        end
                        else
                        begin
                            state_next = S_CHAR;
                        end
                    end
                    MODE_CURSOR:
                    begin
                        if (status.vis_match)
                        begin
                            state_next = S_FINISH;
                        end
                        else
                        begin
                            cmd.rd_cell = 1'b1;
                            state_next  = S_VIS_DRAW;
                        end
                    end
                    MODE_CLEAR:
                    begin
                        state_next = S_CLEAR;
                    end
                    default:
                    begin
                        state_next = S_FINISH;
                    end
                endcase
            end
            S_CUR_DRAW:
            begin
                if (status.out_free)
                begin
                    cmd.emit   = 1'b1;
                    cmd.src    = SRC_PLAIN;
                    state_next = S_CHAR;
                end
            end
            S_CHAR:
            begin
                if (status.is_newline)
                begin
                    cmd.cur_op = CUR_NEWLINE;
                    state_next = status.last_row ? S_SCROLL : S_FINISH;
                end
                else if (status.is_return)
                begin
                    cmd.cur_op = CUR_RETURN;
                    state_next = S_FINISH;
                end
                else if (status.is_backspace)
                begin
                    cmd.cur_op = CUR_BACK;
                    state_next = S_BS_READ;
                end
                else if (status.rem_zero)
                begin
                    state_next = S_FINISH;
                end
                else
                begin
                    state_next = S_PUT;
                end
            end
            S_PUT:
            begin
                if (status.out_free)
                begin
                    cmd.wr_cell = 1'b1;
                    cmd.emit    = 1'b1;
                    cmd.src     = SRC_PUT;
                    cmd.tab_dec = 1'b1;
                    cmd.cur_op  = status.last_col ? CUR_NEWLINE : CUR_ADVANCE;
                    if (status.last_col && status.last_row)
                    begin
                        state_next = S_SCROLL;
                    end
                    else if (status.rem_one)
                    begin
                        state_next = S_FINISH;
                    end
                    else
                    begin
                        state_next = S_PUT;
                    end
                end
            end
            S_SCROLL:
            begin
                if (status.out_free)
                begin
                    cmd.emit   = 1'b1;
                    cmd.src    = SRC_SCROLL;
                    cmd.scroll = 1'b1;
                    state_next = S_SWEEP;
                end
            end
            S_SWEEP:
            begin
                cmd.sweep = 1'b1;
                if (status.sweep_last)
                begin
                    state_next = status.rem_zero ? S_FINISH : S_PUT;
                end
            end
            S_BS_READ:
            begin
                cmd.rd_cell = 1'b1;
                state_next  = S_BS_DRAW;
            end
            S_BS_DRAW:
            begin
                if (status.out_free)
                begin
                    cmd.wr_cell = 1'b1;
                    cmd.emit    = 1'b1;
                    cmd.src     = SRC_BS;
                    state_next  = S_FINISH;
                end
            end
            S_VIS_DRAW:
            begin
                if (status.out_free)
                begin
                    cmd.wr_cell = 1'b1;
                    cmd.emit    = 1'b1;
                    cmd.src     = SRC_VIS;
                    state_next  = S_FINISH;
                end
            end
            S_CLEAR:
            begin
                if (status.out_free)
                begin
                    cmd.emit   = 1'b1;
                    cmd.src    = SRC_CLEAR;
                    cmd.clear  = 1'b1;
                    state_next = S_SWEEP;
                end
            end
            S_FINISH:
            begin
                if (!status.held_valid || status.out_free)
                begin
                    cmd.finish = 1'b1;
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_INIT;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    `TCCE_ASSERT(a_emit_free, !cmd.emit || status.out_free, "result staged while output register busy")
    `TCCE_ASSERT(a_finish_free, !(cmd.finish && status.held_valid && !status.out_free), "final beat flushed into a busy output")
    `TCCE_ASSERT_NEXT(a_accept_busy, item_valid && !item_stall, item_stall, "second item accepted before the first finished")

endmodule

/* rtl/core/text_console_cursor_engine.sv */
// Top level of the text console cursor engine: configuration port and wiring.
// Depends on tcce_pkg, tcce_ctrl and tcce_dp.
//
//   Channel   Handshake                 Payload
//   ------    ------------------------  ------------------------------------
//   item      item_valid / item_stall   item (mode, char, colour, visibility)
//   result    result_valid/result_stall result (command, cell, glyph, flags)
//   config    psel/penable/pwrite/paddr pwdata / prdata, pready always high
//
// A character item is accepted in the idle state; a backspace reads its cell in a state of
// its own. A visibility change that changes nothing gives no result beat. A clear sweeps
// the whole memory and a scroll sweeps its row to blank it. After reset item_stall stays
// high while the memory is cleared. A stalled result beat waits in the output register
// while the next beat waits in a holding register.

module text_console_cursor_engine #(
    parameter int COLUMNS = 40,
    parameter int ROWS    = 16
) (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              psel,
    input  logic                              penable,
    input  logic                              pwrite,
    input  logic [tcce_pkg::APB_ADDR_W-1:0]   paddr,
    input  logic [tcce_pkg::APB_DATA_W-1:0]   pwdata,
    output logic [tcce_pkg::APB_DATA_W-1:0]   prdata,
    output logic                              pready,
    input  logic                              item_valid,
    output logic                              item_stall,
    input  tcce_pkg::item_t                   item,
    output logic                              result_valid,
    input  logic                              result_stall,
    output tcce_pkg::result_t                 result
);
    import tcce_pkg::*;

    logic [15:0] background_colour_reg, background_colour_next;
    logic        reg_write;
    dp_cmd_t     cmd;
    dp_status_t  status;

    assign pready    = 1'b1;
    assign reg_write = psel && penable && pwrite && pready;

    always_comb
    begin
        background_colour_next = background_colour_reg;
        if (reg_write && (paddr[2] == REG_BACKGROUND))
        begin
            background_colour_next = pwdata[15:0];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            background_colour_reg <= '0;
        end
        else
        begin
            background_colour_reg <= background_colour_next;
        end
    end

    always_comb
    begin
        if (paddr[2] == REG_BACKGROUND)
        begin
            prdata = {16'h0000, background_colour_reg};
        end
        else
        begin
            prdata = '0;
        end
    end

    tcce_ctrl u_ctrl (
        .clk        (clk),
        .rst_n      (rst_n),
        .item_valid (item_valid),
        .item_stall (item_stall),
        .status     (status),
        .cmd        (cmd)
    );

    tcce_dp #(
        .COLUMNS (COLUMNS),
        .ROWS    (ROWS)
    ) u_dp (
        .clk               (clk),
        .rst_n             (rst_n),
        .cmd               (cmd),
        .status            (status),
        .item              (item),
        .background_colour (background_colour_reg),
        .result_valid      (result_valid),
        .result            (result),
        .result_stall      (result_stall)
    );

endmodule
